// ===== design/assert_macros.svh =====
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SVRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("svra assertion failed");

`define SVRA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("svra assertion failed");

`else

`define SVRA_ASSERT(lbl, prop)
`define SVRA_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== design/svra_pkg.sv =====
`default_nettype none

package svra_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned FRAC_W  = 12;
  localparam int unsigned CHAN_W  = 13;
  localparam int unsigned NUM_CH  = 3;

  localparam int unsigned SUM_W   = VALUE_W + 2;
  localparam int unsigned AMB_W   = VALUE_W + CHAN_W - FRAC_W;
  localparam int unsigned MIX_W   = AMB_W + 1;

  // divide by three as multiply by reciprocal, exact for any sum below 3 * 2**VALUE_W
  localparam int unsigned DIV3_SH = SUM_W + 1;
  localparam int unsigned DIV3_W  = DIV3_SH - 1;
  localparam logic [DIV3_W-1:0] DIV3_MUL =
    DIV3_W'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);

  localparam logic [CHAN_W-1:0] ONE_Q = CHAN_W'(2 ** FRAC_W);

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_AMB_EN   = 3'd0,
    REG_BLEND_EN = 3'd1,
    REG_AMB_R    = 3'd2,
    REG_AMB_G    = 3'd3,
    REG_AMB_B    = 3'd4,
    REG_REFL_R   = 3'd5,
    REG_REFL_G   = 3'd6,
    REG_REFL_B   = 3'd7
  } reg_idx_e;

  typedef logic [VALUE_W-1:0] val_t;
  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [AMB_W-1:0]   amb_t;
  typedef logic [MIX_W-1:0]   mix_t;
  typedef logic [1:0]         cnt_t;

  typedef struct packed {
    logic               blend_en;
    amb_t [NUM_CH-1:0]  amb_term;
  } cfg_t;

  typedef struct packed {
    sum_t  [NUM_CH-1:0] sum;
    cnt_t               cnt;
    chan_t [NUM_CH-1:0] color;
    logic               last;
  } win_t;

  typedef struct packed {
    mix_t  [NUM_CH-1:0] mix;
    chan_t [NUM_CH-1:0] color;
    logic               last;
  } mix_st_t;

endpackage

`default_nettype wire

// ===== design/svra_if.sv =====
`default_nettype none

interface svra_in_if;
  import svra_pkg::*;

  logic  valid;
  logic  ready;
  val_t  patch_red;
  val_t  patch_green;
  val_t  patch_blue;
  logic  patch_present;
  chan_t color_red;
  chan_t color_green;
  chan_t color_blue;
  logic  strip_start;
  logic  strip_end;

  modport source (
    output valid, patch_red, patch_green, patch_blue, patch_present,
           color_red, color_green, color_blue, strip_start, strip_end,
    input  ready
  );

  modport sink (
    input  valid, patch_red, patch_green, patch_blue, patch_present,
           color_red, color_green, color_blue, strip_start, strip_end,
    output ready
  );
endinterface

interface svra_out_if;
  import svra_pkg::*;

  logic  valid;
  logic  ready;
  chan_t vertex_red;
  chan_t vertex_green;
  chan_t vertex_blue;
  logic  vertex_last;

  modport source (
    output valid, vertex_red, vertex_green, vertex_blue, vertex_last,
    input  ready
  );

  modport sink (
    input  valid, vertex_red, vertex_green, vertex_blue, vertex_last,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/svra_cfg.sv =====
`default_nettype none

module svra_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [svra_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [svra_pkg::DATA_W-1:0]   pwdata_i,
  output logic [svra_pkg::DATA_W-1:0]   prdata_o,
  output svra_pkg::cfg_t                cfg_o
);
  import svra_pkg::*;

  localparam int unsigned PROD_W = VALUE_W + CHAN_W;

  logic                 wr_en;
  reg_idx_e             idx;
  logic                 amb_en_q;
  logic                 blend_en_q;
  val_t  [NUM_CH-1:0]   amb_q;
  chan_t [NUM_CH-1:0]   refl_q;
  amb_t  [NUM_CH-1:0]   amb_term_d;
  amb_t  [NUM_CH-1:0]   amb_term_q;
  logic  [PROD_W-1:0]   prod [NUM_CH];

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_en_q   <= 1'b0;
      blend_en_q <= 1'b0;
      amb_q      <= '0;
      refl_q     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_AMB_EN:   amb_en_q   <= pwdata_i[0];
        REG_BLEND_EN: blend_en_q <= pwdata_i[0];
        REG_AMB_R:    amb_q[0]   <= pwdata_i[VALUE_W-1:0];
        REG_AMB_G:    amb_q[1]   <= pwdata_i[VALUE_W-1:0];
        REG_AMB_B:    amb_q[2]   <= pwdata_i[VALUE_W-1:0];
        REG_REFL_R:   refl_q[0]  <= pwdata_i[CHAN_W-1:0];
        REG_REFL_G:   refl_q[1]  <= pwdata_i[CHAN_W-1:0];
        REG_REFL_B:   refl_q[2]  <= pwdata_i[CHAN_W-1:0];
      endcase
    end
  end

  // ambient times reflectance, kept ready ahead of the datapath
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k]       = PROD_W'(amb_q[k]) * PROD_W'(refl_q[k]);
      amb_term_d[k] = amb_en_q ? prod[k][PROD_W-1:FRAC_W] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_term_q <= '0;
    end else begin
      amb_term_q <= amb_term_d;
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (idx)
      REG_AMB_EN:   prdata_o = DATA_W'(amb_en_q);
      REG_BLEND_EN: prdata_o = DATA_W'(blend_en_q);
      REG_AMB_R:    prdata_o = DATA_W'(amb_q[0]);
      REG_AMB_G:    prdata_o = DATA_W'(amb_q[1]);
      REG_AMB_B:    prdata_o = DATA_W'(amb_q[2]);
      REG_REFL_R:   prdata_o = DATA_W'(refl_q[0]);
      REG_REFL_G:   prdata_o = DATA_W'(refl_q[1]);
      REG_REFL_B:   prdata_o = DATA_W'(refl_q[2]);
    endcase
  end

  assign cfg_o.blend_en = blend_en_q;
  assign cfg_o.amb_term = amb_term_q;

endmodule

`default_nettype wire

// ===== design/svra_window.sv =====
`default_nettype none

module svra_window (
  input  logic            clk_i,
  input  logic            rst_ni,
  svra_in_if.sink         in_i,
  input  logic            adv_i,
  output logic            win_valid_o,
  output svra_pkg::win_t  win_o
);
  import svra_pkg::*;

  logic               ready;
  logic               accept;
  val_t  [NUM_CH-1:0] cur;
  val_t  [NUM_CH-1:0] prev0_q;
  val_t  [NUM_CH-1:0] prev1_q;
  val_t  [NUM_CH-1:0] p0;
  val_t  [NUM_CH-1:0] p1;
  logic  [1:0]        pres_q;
  logic  [1:0]        pres;
  win_t               win_d;
  win_t               win_q;
  logic               valid_q;

  assign ready      = !valid_q || adv_i;
  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  // strip start empties the window before this vertex
  assign pres = in_i.strip_start ? 2'b00 : pres_q;

  always_comb begin
    cur[0] = in_i.patch_present ? in_i.patch_red   : '0;
    cur[1] = in_i.patch_present ? in_i.patch_green : '0;
    cur[2] = in_i.patch_present ? in_i.patch_blue  : '0;
    for (int k = 0; k < NUM_CH; k++) begin
      p0[k]        = pres[0] ? prev0_q[k] : '0;
      p1[k]        = pres[1] ? prev1_q[k] : '0;
      win_d.sum[k] = SUM_W'(cur[k]) + SUM_W'(p0[k]) + SUM_W'(p1[k]);
    end
    win_d.cnt      = cnt_t'(in_i.patch_present) + cnt_t'(pres[0]) + cnt_t'(pres[1]);
    win_d.color[0] = in_i.color_red;
    win_d.color[1] = in_i.color_green;
    win_d.color[2] = in_i.color_blue;
    win_d.last     = in_i.strip_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev0_q <= '0;
      prev1_q <= '0;
      pres_q  <= 2'b00;
    end else if (accept) begin
      if (in_i.strip_end) begin
        prev0_q <= '0;
        prev1_q <= '0;
        pres_q  <= 2'b00;
      end else begin
        prev1_q <= p0;
        prev0_q <= cur;
        pres_q  <= {pres[0], in_i.patch_present};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  assign win_valid_o = valid_q;
  assign win_o       = win_q;

endmodule

`default_nettype wire

// ===== design/svra_shade.sv =====
`default_nettype none

module svra_shade (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            win_valid_i,
  input  svra_pkg::win_t  win_i,
  input  svra_pkg::cfg_t  cfg_i,
  output logic            take_o,
  svra_out_if.source      out_o
);
  import svra_pkg::*;

  localparam int unsigned DPROD_W = SUM_W + DIV3_W;
  localparam int unsigned BPROD_W = MIX_W + CHAN_W;
  localparam int unsigned BL_W    = BPROD_W - FRAC_W;

  logic                 out_en;
  logic                 s2_en;
  logic [DPROD_W-1:0]   dprod [NUM_CH];
  val_t [NUM_CH-1:0]    mean;
  mix_st_t              s2_d;
  mix_st_t              s2_q;
  logic                 s2v_q;
  logic [BPROD_W-1:0]   bprod [NUM_CH];
  logic [BL_W-1:0]      blended [NUM_CH];
  chan_t [NUM_CH-1:0]   res_d;
  chan_t [NUM_CH-1:0]   res_q;
  logic                 last_q;
  logic                 ov_q;

  assign out_en = !ov_q || out_o.ready;
  assign s2_en  = !s2v_q || out_en;
  assign take_o = s2_en;

  // mean of the present patches plus ambient
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      dprod[k] = DPROD_W'(win_i.sum[k]) * DPROD_W'(DIV3_MUL);
      case (win_i.cnt)
        2'd0:    mean[k] = '0;
        2'd1:    mean[k] = win_i.sum[k][VALUE_W-1:0];
        2'd2:    mean[k] = win_i.sum[k][VALUE_W:1];
        default: mean[k] = dprod[k][DIV3_SH +: VALUE_W];
      endcase
      s2_d.mix[k] = MIX_W'(mean[k]) + MIX_W'(cfg_i.amb_term[k]);
    end
    s2_d.color = win_i.color;
    s2_d.last  = win_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2v_q <= 1'b0;
    end else if (s2_en) begin
      s2v_q <= win_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && win_valid_i) begin
      s2_q <= s2_d;
    end
  end

  // color blend when blend_en is set, then clamp to one
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      bprod[k]   = BPROD_W'(s2_q.mix[k]) * BPROD_W'(s2_q.color[k]);
      blended[k] = cfg_i.blend_en ? bprod[k][BPROD_W-1:FRAC_W] : BL_W'(s2_q.mix[k]);
      res_d[k]   = (blended[k] > BL_W'(ONE_Q)) ? ONE_Q : blended[k][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_en) begin
      ov_q <= s2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2v_q) begin
      res_q  <= res_d;
      last_q <= s2_q.last;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.vertex_red   = res_q[0];
  assign out_o.vertex_green = res_q[1];
  assign out_o.vertex_blue  = res_q[2];
  assign out_o.vertex_last  = last_q;

endmodule

`default_nettype wire

// ===== design/strip_vertex_radiosity_average_core.sv =====
// channel   kind         handshake        beat contents
// in_i      stream sink  valid / ready    patch rgb, patch_present, color rgb, strip flags
// out_o     stream src   valid / ready    vertex rgb clamped to 1.0, vertex_last
// apb       cfg slave    psel / penable   eight registers at byte address 4 * index
//
// one beat per cycle sustained while the output is not stalled; each beat is registered in every stage
// stages: window sum and count, mean plus ambient, color blend and clamp
// reset clears the patch window, the registers and all stage valids
// a stalled output backs up stage by stage; input ready drops only when all stages are full
`default_nettype none

`include "assert_macros.svh"

module strip_vertex_radiosity_average_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  svra_in_if.sink                       in_i,
  svra_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svra_pkg::ADDR_W-1:0]   paddr,
  input  logic [svra_pkg::DATA_W-1:0]   pwdata,
  output logic [svra_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import svra_pkg::*;

  cfg_t cfg;
  win_t win;
  logic win_valid;
  logic win_take;

  assign pready = 1'b1;

  svra_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  svra_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .adv_i       (win_take),
    .win_valid_o (win_valid),
    .win_o       (win)
  );

  svra_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid),
    .win_i       (win),
    .cfg_i       (cfg),
    .take_o      (win_take),
    .out_o       (out_o)
  );

  `SVRA_ASSERT(a_win_hold, (win_valid && !win_take) |=> win_valid)
  `SVRA_ASSERT(a_in_lands, (in_i.valid && in_i.ready) |=> win_valid)
  `SVRA_ASSERT(a_stall_full, !in_i.ready |-> (win_valid && !win_take))
  `SVRA_ASSERT_ALWAYS(a_clamp, out_o.valid |-> (out_o.vertex_red <= ONE_Q && out_o.vertex_green <= ONE_Q && out_o.vertex_blue <= ONE_Q))

endmodule

`default_nettype wire
